// ----- sv/gabc_pkg.sv -----
// Shared types and constants for the gyro assist blend controller.
// Used by gabc_div and gyro_assist_blend_controller_core; no dependencies.
`default_nettype none

package gabc_pkg;

  localparam int AXES           = 3;
  localparam int MAX_DT_US      = 50000;
  localparam int MAX_LPF        = 500;
  localparam int MIN_TRANSITION = 50;
  localparam int MAX_TRANSITION = 5000;
  localparam int TRANSITION_RST = 500;
  localparam int TIMEOUT_RST    = 50;

  localparam int ONE_CMD    = 16384;
  localparam int ONE_Q15    = 32768;
  localparam int TWO_PI_Q16 = 411775;
  localparam int MS_TO_US   = 1000;
  // One second in microseconds, scaled to Q16.
  localparam longint ALPHA_DEN_BASE = 64'd65536000000;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 47;
  localparam int DIV_Q_W   = 32;

  localparam int FLAG_FIXEDWING   = 0;
  localparam int FLAG_ARMED       = 1;
  localparam int FLAG_FAILSAFE    = 2;
  localparam int FLAG_GYROVALID   = 3;
  localparam int FLAG_REQUESTED   = 4;
  localparam int FLAG_NAV         = 5;
  localparam int FLAG_LAUNCH      = 6;
  localparam int FLAG_AUTOTRIM    = 7;
  localparam int FLAG_MODEALLOWED = 8;

  typedef enum logic [2:0] {
    PH_INACTIVE  = 3'd0,
    PH_ENTERING  = 3'd1,
    PH_ACTIVE    = 3'd2,
    PH_EXITING   = 3'd3,
    PH_INHIBITED = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    RS_NONE         = 4'd0,
    RS_NOT_REQ      = 4'd1,
    RS_NAV          = 4'd2,
    RS_LAUNCH       = 4'd3,
    RS_AUTOTRIM     = 4'd4,
    RS_MODE         = 4'd5,
    RS_NOT_FW       = 4'd6,
    RS_DISARMED     = 4'd7,
    RS_FAILSAFE     = 4'd8,
    RS_BAD_CFG      = 4'd9,
    RS_GYRO_INVALID = 4'd10,
    RS_GYRO_STALE   = 4'd11,
    RS_BAD_DT       = 4'd12,
    RS_BAD_INPUT    = 4'd13
  } reason_t;

  typedef enum logic [2:0] {
    CFG_GYRO_GAINS   = 3'd0,
    CFG_CORR_LIMITS  = 3'd1,
    CFG_STICK_PRIO   = 3'd2,
    CFG_RELEASE_MS   = 3'd3,
    CFG_LOCK_MS      = 3'd4,
    CFG_LPF_HZ       = 3'd5,
    CFG_TRANSITION   = 3'd6,
    CFG_GYRO_TIMEOUT = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK,
    ST_ALPHA_M1, ST_ALPHA_M2, ST_ALPHA_S, ST_ALPHA_DIV,
    ST_FILT_M, ST_FILT_W,
    ST_BLEND_M, ST_BLEND_S, ST_BLEND_DIV,
    ST_PRI, ST_PRI_MW, ST_PRI_DIV,
    ST_GAIN, ST_GAIN_M1, ST_GAIN_M2, ST_GAIN_S, ST_GAIN_DIV,
    ST_EFF_M, ST_EFF_W, ST_RAW_M, ST_RAW_W, ST_MIX_M, ST_MIX_W,
    ST_DONE
  } seq_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

endpackage

`default_nettype wire

// ----- sv/gabc_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the controller.
// Depends on gabc_pkg. The upper half of the numerator must be below the divisor.
`default_nettype none

module gabc_div (
  input  logic               clk,
  input  logic               rst,
  input  gabc_pkg::div_req_t req,
  output logic               done,
  output logic [gabc_pkg::DIV_Q_W-1:0] quot
);
  import gabc_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_Q_W-1:0]   qb;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;

  assign shifted = {rem, qb[DIV_Q_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign quot    = qb;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_Q_W]);
        qb   <= req.num[DIV_Q_W-1:0];
        dvs  <= req.den;
        cnt  <= CNT_W'(DIV_Q_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DIV_DEN_W'(shifted - {1'b0, dvs}) : shifted[DIV_DEN_W-1:0];
        qb  <= {qb[DIV_Q_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with an exhausted count");

endmodule

`default_nettype wire

// ----- sv/gyro_assist_blend_controller_core.sv -----
// Gyro assist blend controller: tick sequencer, phase machine and per-axis datapath.
// Depends on gabc_pkg and gabc_div.
`default_nettype none

// One tick is taken per input transfer and yields one result transfer. A tick
// that falls back (dormant or hard inhibit) goes straight to the result. A full
// tick runs one shared 27x20 multiplier and the shared 32-step divider under a
// small sequencer; the divider is used up to eight times (filter coefficient,
// blend step, and per axis the priority target and the gain smoothing step). The
// block takes no input while a tick is in progress; a finished result waits in
// the output register and does not hold up the next input transfer.
module gyro_assist_blend_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] delta_time_us,
  input  logic [31:0] now_ms,
  input  logic [31:0] gyro_sample_ms,
  input  logic [8:0]  condition_flags,
  input  logic [47:0] pilot_commands,
  input  logic [47:0] fallback_commands,
  input  logic [47:0] gyro_rates,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  phase,
  output logic [3:0]  reason,
  output logic        hard_inhibit,
  output logic [15:0] blend,
  output logic        using_assist,
  output logic [47:0] final_commands,
  output logic [47:0] surface_commands,
  output logic [47:0] corrections,
  output logic [2:0]  correction_limited,
  output logic [47:0] filtered_rates,
  output logic [47:0] priority_scales,
  output logic [47:0] effective_gains
);
  import gabc_pkg::*;

  function automatic logic signed [15:0] clamp_cmd(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'(ONE_CMD)) r = 16'(ONE_CMD);
    else if (v < -18'(ONE_CMD)) r = -16'(ONE_CMD);
    else r = v[15:0];
    return r;
  endfunction

  // Configuration registers.
  logic [47:0] gyro_gains, correction_limits, stick_priorities;
  logic [47:0] release_times_ms, lock_times_ms;
  logic [8:0]  lpf_hz;
  logic [15:0] transition_ms, gyro_timeout_ms;

  // Persistent controller state.
  phase_t             phase_reg;
  logic [15:0]        blend_reg;
  logic               filter_ready;
  logic signed [23:0] filtered_rate [AXES];
  logic [15:0]        gain_scale [AXES];

  // Latched tick.
  logic [15:0] item_dt;
  logic [31:0] item_now, item_sample;
  logic [8:0]  item_flags;
  logic [47:0] item_pilot, item_fallback, item_rates;

  // Sequencer and work registers.
  seq_t               st, st_next;
  logic [1:0]         ax;
  logic               init_scale;
  logic [16:0]        alpha;
  logic [15:0]        tgt;
  logic [15:0]        tms_sel;
  logic [25:0]        gden;
  logic               gneg;
  logic [15:0]        eff;
  logic signed [15:0] surf_s;
  logic signed [46:0] mul_p;
  logic signed [26:0] mul_a;
  logic signed [19:0] mul_b;

  // Result staging.
  phase_t      acc_phase;
  reason_t     acc_reason;
  logic        acc_hard, acc_using;
  logic [15:0] acc_blend;
  logic [47:0] acc_final, acc_surf, acc_corr, acc_filt, acc_scale, acc_eff;
  logic [2:0]  acc_lim;

  div_req_t                div_req;
  logic                    div_done;
  logic [DIV_Q_W-1:0]      div_quot;

  gabc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // Tick conditions.
  reason_t hard_why, req_why;
  logic    dormant, target, stale, cfg_bad;

  assign stale   = (item_now - item_sample) > 32'(gyro_timeout_ms);
  assign cfg_bad = lpf_hz > 9'(MAX_LPF) || transition_ms < 16'(MIN_TRANSITION) ||
                   transition_ms > 16'(MAX_TRANSITION) || gyro_timeout_ms == '0;
  assign dormant = !item_flags[FLAG_REQUESTED] && blend_reg == '0;
  assign target  = req_why == RS_NONE;

  always_comb begin
    priority if (!item_flags[FLAG_FIXEDWING]) hard_why = RS_NOT_FW;
    else if (!item_flags[FLAG_ARMED]) hard_why = RS_DISARMED;
    else if (item_flags[FLAG_FAILSAFE]) hard_why = RS_FAILSAFE;
    else if (cfg_bad) hard_why = RS_BAD_CFG;
    else if (!item_flags[FLAG_GYROVALID]) hard_why = RS_GYRO_INVALID;
    else if (stale) hard_why = RS_GYRO_STALE;
    else if (item_dt == '0 || item_dt > 16'(MAX_DT_US)) hard_why = RS_BAD_DT;
    else hard_why = RS_NONE;

    priority if (!item_flags[FLAG_REQUESTED]) req_why = RS_NOT_REQ;
    else if (item_flags[FLAG_NAV]) req_why = RS_NAV;
    else if (item_flags[FLAG_LAUNCH]) req_why = RS_LAUNCH;
    else if (item_flags[FLAG_AUTOTRIM]) req_why = RS_AUTOTRIM;
    else if (!item_flags[FLAG_MODEALLOWED]) req_why = RS_MODE;
    else req_why = RS_NONE;
  end

  // Lanes of the current axis.
  logic [15:0]        prio, gg, lim_lane, rel_ms, lock_ms;
  logic signed [15:0] pilot_c, fb_c, rate_raw;
  logic [14:0]        stick;
  logic signed [23:0] frate_cur, rate_x256;
  logic signed [24:0] fdiff;
  logic [15:0]        scale_cur, scale_eff;
  logic signed [16:0] gdiff, mdiff;
  logic [16:0]        zpt;

  assign prio      = stick_priorities[16*ax +: 16];
  assign gg        = gyro_gains[16*ax +: 16];
  assign lim_lane  = correction_limits[16*ax +: 16];
  assign rel_ms    = release_times_ms[16*ax +: 16];
  assign lock_ms   = lock_times_ms[16*ax +: 16];
  assign pilot_c   = clamp_cmd(18'(signed'(item_pilot[16*ax +: 16])));
  assign fb_c      = clamp_cmd(18'(signed'(item_fallback[16*ax +: 16])));
  assign rate_raw  = signed'(item_rates[16*ax +: 16]);
  assign stick     = pilot_c[15] ? 15'(-pilot_c) : 15'(pilot_c);
  assign frate_cur = filtered_rate[ax];
  assign rate_x256 = {rate_raw, 8'b0};
  assign fdiff     = 25'(rate_x256) - 25'(frate_cur);
  assign scale_cur = gain_scale[ax];
  assign scale_eff = init_scale ? tgt : scale_cur;
  assign gdiff     = signed'({1'b0, tgt}) - signed'({1'b0, scale_cur});
  assign mdiff     = 17'(surf_s) - 17'(fb_c);
  assign zpt       = 17'(ONE_Q15) - 17'(prio);

  // Rounded views of the registered product.
  logic signed [46:0] p_r16, p_r15, p_r13, p_r6;
  logic [46:0]        aden;
  logic [46:0]        gmag;
  assign p_r16 = (mul_p + 47'sd32768) >>> 16;
  assign p_r15 = (mul_p + 47'sd16384) >>> 15;
  assign p_r13 = (mul_p + 47'sd4096) >>> 13;
  assign p_r6  = (mul_p + 47'sd32) >>> 6;
  assign aden  = 47'(ALPHA_DEN_BASE) + 47'(mul_p[43:0]);
  assign gmag  = mul_p[46] ? 47'(-mul_p) : 47'(mul_p);

  // Blend ramp step and phase machine update.
  logic [16:0] bstep;
  logic [17:0] bsum;
  logic [15:0] blend_next;
  phase_t      phase_next;
  logic        drop_filter;

  always_comb begin
    bstep       = (div_quot > 32'(ONE_Q15)) ? 17'(ONE_Q15) : div_quot[16:0];
    bsum        = 18'(blend_reg) + 18'(bstep);
    blend_next  = blend_reg;
    phase_next  = phase_reg;
    drop_filter = 1'b0;
    if (target) begin
      unique case (phase_reg)
        PH_ENTERING: begin
          if (bsum >= 18'(ONE_Q15)) begin
            blend_next = 16'(ONE_Q15);
            phase_next = PH_ACTIVE;
          end else begin
            blend_next = bsum[15:0];
          end
        end
        PH_EXITING: phase_next = PH_ENTERING;
        PH_ACTIVE:  phase_next = PH_ACTIVE;
        default: begin
          blend_next = '0;
          phase_next = PH_ENTERING;
        end
      endcase
    end else begin
      unique case (phase_reg)
        PH_ACTIVE, PH_ENTERING: phase_next = PH_EXITING;
        PH_EXITING: begin
          if (17'(blend_reg) <= bstep) begin
            blend_next  = '0;
            phase_next  = PH_INACTIVE;
            drop_filter = 1'b1;
          end else begin
            blend_next = blend_reg - bstep[15:0];
          end
        end
        default: begin
          blend_next  = '0;
          phase_next  = PH_INACTIVE;
          drop_filter = 1'b1;
        end
      endcase
    end
  end

  // Per-axis correction, surface and final command.
  logic signed [15:0] limv, corr_c;
  logic               corr_lim;
  logic signed [15:0] surf_c, fin_c;
  logic [15:0]        pri_lin, pri_div;
  logic signed [24:0] filt_rnd;

  always_comb begin
    limv     = (lim_lane > 16'd32767) ? 16'sd32767 : signed'(lim_lane);
    corr_lim = 1'b1;
    if (p_r6 > 47'(limv)) corr_c = limv;
    else if (p_r6 < -47'(limv)) corr_c = -limv;
    else begin
      corr_c   = p_r6[15:0];
      corr_lim = 1'b0;
    end
    surf_c   = clamp_cmd(18'(pilot_c) + 18'(corr_c));
    fin_c    = clamp_cmd(18'(fb_c) + 18'(p_r15));
    pri_lin  = (p_r13 >= 47'(ONE_Q15)) ? '0 : 16'(47'(ONE_Q15) - p_r13);
    pri_div  = (div_quot >= 32'(ONE_Q15)) ? '0 : 16'(32'(ONE_Q15) - div_quot);
    filt_rnd = (25'(frate_cur) + 25'sd128) >>> 8;
  end

  // Sequencer: next state, shared multiplier operands and divider requests.
  always_comb begin
    st_next     = st;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    unique case (st)
      ST_IDLE:  if (in_valid) st_next = ST_CHECK;
      ST_CHECK: begin
        if (dormant || hard_why != RS_NONE) st_next = ST_DONE;
        else if (!filter_ready || lpf_hz == '0) st_next = ST_BLEND_M;
        else st_next = ST_ALPHA_M1;
      end
      ST_ALPHA_M1: begin
        mul_a   = signed'({11'b0, item_dt});
        mul_b   = signed'({11'b0, lpf_hz});
        st_next = ST_ALPHA_M2;
      end
      ST_ALPHA_M2: begin
        mul_a   = signed'(mul_p[26:0]);
        mul_b   = 20'(TWO_PI_Q16);
        st_next = ST_ALPHA_S;
      end
      ST_ALPHA_S: begin
        div_req.start = 1'b1;
        div_req.num   = 64'({mul_p[43:0], 16'b0}) + 64'(aden >> 1);
        div_req.den   = aden;
        st_next       = ST_ALPHA_DIV;
      end
      ST_ALPHA_DIV: if (div_done) st_next = ST_FILT_M;
      ST_FILT_M: begin
        mul_a   = 27'(fdiff);
        mul_b   = signed'({3'b0, alpha});
        st_next = ST_FILT_W;
      end
      ST_FILT_W: st_next = (ax == 2'(AXES - 1)) ? ST_BLEND_M : ST_FILT_M;
      ST_BLEND_M: begin
        mul_a   = signed'({11'b0, transition_ms});
        mul_b   = 20'(MS_TO_US);
        st_next = ST_BLEND_S;
      end
      ST_BLEND_S: begin
        div_req.start = 1'b1;
        div_req.num   = 64'({item_dt, 15'b0}) + 64'(mul_p[22:0]) - 64'd1;
        div_req.den   = 47'(mul_p[22:0]);
        st_next       = ST_BLEND_DIV;
      end
      ST_BLEND_DIV: if (div_done) st_next = ST_PRI;
      ST_PRI: begin
        mul_a = signed'({12'b0, stick});
        mul_b = signed'({4'b0, prio});
        if (prio <= 16'(ONE_CMD)) st_next = ST_PRI_MW;
        else if (prio >= 16'(ONE_Q15)) st_next = ST_GAIN;
        else begin
          div_req.start = 1'b1;
          div_req.num   = 64'({stick, 15'b0}) + 64'(zpt >> 1);
          div_req.den   = 47'(zpt);
          st_next       = ST_PRI_DIV;
        end
      end
      ST_PRI_MW:  st_next = ST_GAIN;
      ST_PRI_DIV: if (div_done) st_next = ST_GAIN;
      ST_GAIN: begin
        if (((tgt < scale_eff) ? rel_ms : lock_ms) == '0) st_next = ST_EFF_M;
        else st_next = ST_GAIN_M1;
      end
      ST_GAIN_M1: begin
        mul_a   = signed'({11'b0, tms_sel});
        mul_b   = 20'(MS_TO_US);
        st_next = ST_GAIN_M2;
      end
      ST_GAIN_M2: begin
        mul_a   = 27'(gdiff);
        mul_b   = signed'({4'b0, item_dt});
        st_next = ST_GAIN_S;
      end
      ST_GAIN_S: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(gmag[31:0]) + 64'(gden >> 1);
        div_req.den   = 47'(gden);
        st_next       = ST_GAIN_DIV;
      end
      ST_GAIN_DIV: if (div_done) st_next = ST_EFF_M;
      ST_EFF_M: begin
        mul_a   = signed'({11'b0, gg});
        mul_b   = signed'({4'b0, scale_cur});
        st_next = ST_EFF_W;
      end
      ST_EFF_W: st_next = ST_RAW_M;
      ST_RAW_M: begin
        mul_a   = -27'(frate_cur);
        mul_b   = signed'({4'b0, eff});
        st_next = ST_RAW_W;
      end
      ST_RAW_W: st_next = ST_MIX_M;
      ST_MIX_M: begin
        mul_a   = 27'(mdiff);
        mul_b   = signed'({4'b0, blend_reg});
        st_next = ST_MIX_W;
      end
      ST_MIX_W: st_next = (ax == 2'(AXES - 1)) ? ST_DONE : ST_PRI;
      ST_DONE:  if (!out_valid || out_ready) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  assign in_ready = st == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    mul_p <= 47'(mul_a) * 47'(mul_b);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_gains        <= '0;
      correction_limits <= '0;
      stick_priorities  <= '0;
      release_times_ms  <= '0;
      lock_times_ms     <= '0;
      lpf_hz            <= '0;
      transition_ms     <= 16'(TRANSITION_RST);
      gyro_timeout_ms   <= 16'(TIMEOUT_RST);
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GYRO_GAINS:   gyro_gains        <= cfg_data;
        CFG_CORR_LIMITS:  correction_limits <= cfg_data;
        CFG_STICK_PRIO:   stick_priorities  <= cfg_data;
        CFG_RELEASE_MS:   release_times_ms  <= cfg_data;
        CFG_LOCK_MS:      lock_times_ms     <= cfg_data;
        CFG_LPF_HZ:       lpf_hz            <= cfg_data[8:0];
        CFG_TRANSITION:   transition_ms     <= cfg_data[15:0];
        CFG_GYRO_TIMEOUT: gyro_timeout_ms   <= cfg_data[15:0];
        default:          lpf_hz            <= lpf_hz;
      endcase
    end
  end

  // Datapath and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= PH_INACTIVE;
      blend_reg    <= '0;
      filter_ready <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        filtered_rate[a] <= '0;
        gain_scale[a]    <= '0;
      end
      ax <= '0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (in_valid) begin
            item_dt       <= delta_time_us;
            item_now      <= now_ms;
            item_sample   <= gyro_sample_ms;
            item_flags    <= condition_flags;
            item_pilot    <= pilot_commands;
            item_fallback <= fallback_commands;
            item_rates    <= gyro_rates;
          end
        end
        ST_CHECK: begin
          ax         <= '0;
          init_scale <= !filter_ready;
          acc_hard   <= 1'b0;
          acc_lim    <= '0;
          acc_reason <= req_why;
          if (dormant || hard_why != RS_NONE) begin
            // Fallback tick: all state is dropped and the clamped inputs pass.
            phase_reg    <= dormant ? PH_INACTIVE : PH_INHIBITED;
            blend_reg    <= '0;
            filter_ready <= 1'b0;
            acc_phase    <= dormant ? PH_INACTIVE : PH_INHIBITED;
            acc_reason   <= dormant ? RS_NOT_REQ : hard_why;
            acc_hard     <= !dormant;
            acc_blend    <= '0;
            acc_using    <= 1'b0;
            acc_corr     <= '0;
            acc_filt     <= '0;
            acc_scale    <= '0;
            acc_eff      <= '0;
            for (int a = 0; a < AXES; a++) begin
              filtered_rate[a]      <= '0;
              gain_scale[a]         <= '0;
              acc_surf[16*a +: 16]  <= clamp_cmd(18'(signed'(item_pilot[16*a +: 16])));
              acc_final[16*a +: 16] <= clamp_cmd(18'(signed'(item_fallback[16*a +: 16])));
            end
          end else if (!filter_ready || lpf_hz == '0) begin
            filter_ready <= 1'b1;
            for (int a = 0; a < AXES; a++) begin
              filtered_rate[a] <= {item_rates[16*a +: 16], 8'b0};
            end
          end
        end
        ST_ALPHA_DIV: if (div_done) alpha <= div_quot[16:0];
        ST_FILT_W: begin
          filtered_rate[ax] <= frate_cur + p_r16[23:0];
          ax <= (ax == 2'(AXES - 1)) ? '0 : ax + 2'd1;
        end
        ST_BLEND_DIV: begin
          if (div_done) begin
            phase_reg <= phase_next;
            blend_reg <= blend_next;
            if (drop_filter) filter_ready <= 1'b0;
            acc_phase <= phase_next;
            acc_blend <= blend_next;
            acc_using <= target || blend_next != '0;
          end
        end
        ST_PRI: begin
          if (prio >= 16'(ONE_Q15)) tgt <= (stick != '0) ? '0 : 16'(ONE_Q15);
        end
        ST_PRI_MW:  tgt <= pri_lin;
        ST_PRI_DIV: if (div_done) tgt <= pri_div;
        ST_GAIN: begin
          if (((tgt < scale_eff) ? rel_ms : lock_ms) == '0) gain_scale[ax] <= tgt;
          else gain_scale[ax] <= scale_eff;
          tms_sel <= (tgt < scale_eff) ? rel_ms : lock_ms;
        end
        ST_GAIN_M2: begin
          gden <= mul_p[25:0] + 26'(item_dt);
        end
        ST_GAIN_S: gneg <= mul_p[46];
        ST_GAIN_DIV: begin
          if (div_done) begin
            if (gneg) begin
              gain_scale[ax] <= (17'(div_quot) >= 17'(scale_cur)) ? '0
                                : scale_cur - div_quot[15:0];
            end else begin
              gain_scale[ax] <= (17'(scale_cur) + 17'(div_quot) >= 17'(ONE_Q15))
                                ? 16'(ONE_Q15) : scale_cur + div_quot[15:0];
            end
          end
        end
        ST_EFF_W: eff <= p_r15[15:0];
        ST_RAW_W: begin
          surf_s                <= surf_c;
          acc_corr[16*ax +: 16] <= corr_c;
          acc_surf[16*ax +: 16] <= surf_c;
          acc_lim[ax]           <= corr_lim;
        end
        ST_MIX_W: begin
          acc_final[16*ax +: 16] <= fin_c;
          acc_filt[16*ax +: 16]  <= filt_rnd[15:0];
          acc_scale[16*ax +: 16] <= scale_cur;
          acc_eff[16*ax +: 16]   <= eff;
          ax <= (ax == 2'(AXES - 1)) ? '0 : ax + 2'd1;
        end
        default: ax <= ax;
      endcase
    end
  end

  // Output register; a held result does not block the next input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (st == ST_DONE && (!out_valid || out_ready)) begin
        out_valid          <= 1'b1;
        phase              <= acc_phase;
        reason             <= acc_reason;
        hard_inhibit       <= acc_hard;
        blend              <= acc_blend;
        using_assist       <= acc_using;
        final_commands     <= acc_final;
        surface_commands   <= acc_surf;
        corrections        <= acc_corr;
        correction_limited <= acc_lim;
        filtered_rates     <= acc_filt;
        priority_scales    <= acc_scale;
        effective_gains    <= acc_eff;
      end
    end
  end

  a_active_full: assert property (@(posedge clk) disable iff (rst)
      phase_reg == PH_ACTIVE |-> blend_reg == 16'(ONE_Q15))
    else $error("active phase without full blend");
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
      (phase_reg == PH_INACTIVE || phase_reg == PH_INHIBITED) |-> blend_reg == '0)
    else $error("inactive or inhibited phase with nonzero blend");

endmodule

`default_nettype wire
